@@ hdl/imsq_pkg.sv @@
// ----------------------------------------------------------------------------
// imsq_pkg: shared types and constants of the immediate sequencer
// Result word layout, per-stage payload structs and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package imsq_pkg;

  typedef enum logic [2:0] {
    KIND_MOV  = 3'd0,
    KIND_MOVZ = 3'd1,
    KIND_MOVN = 3'd2,
    KIND_MOVK = 3'd3,
    KIND_BFM  = 3'd4
  } kind_t;

  localparam logic [15:0] CHUNK_ONES = 16'hFFFF;
  localparam logic [5:0]  BFM_SHIFT  = 6'd32;
  localparam int          MAX_RESULTS = 4;

  // One emitted instruction.
  typedef struct packed {
    kind_t       kind;
    logic [4:0]  dest_reg;
    logic [63:0] operand;
    logic [5:0]  shift;
    logic        last;
  } result_t;

  // Item fields and precomputed flags that ride along the test stages.
  typedef struct packed {
    logic [4:0]  dest_reg;
    logic [63:0] value;
    logic        is_64bit;
    logic        wide;      // move-wide or inverted move-wide fits
    logic        trivial;   // replicated pattern is all zeros or all ones
    logic [3:0]  chunk_zero;
    logic [3:0]  chunk_ones;
    logic        halves_eq;
  } carry_t;

  // Complete instruction run of one item.
  typedef struct packed {
    result_t [MAX_RESULTS-1:0] ent;
    logic [2:0]                cnt;
  } plan_t;

  function automatic logic at_most_one(input logic [3:0] b);
    return (b & (b - 4'd1)) == 4'd0;
  endfunction

endpackage

`default_nettype wire

@@ hdl/imsq_classify.sv @@
// ----------------------------------------------------------------------------
// imsq_classify: immediate classification pipeline
// Three register stages: move-wide and rotation tests, bitmask element
// extraction, and the run-of-ones addition of the bitmask rule.
// ----------------------------------------------------------------------------
`default_nettype none

module imsq_classify (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [4:0]      in_reg,
  input  wire logic [63:0]     in_value,
  input  wire logic            in_is_64bit,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output imsq_pkg::carry_t     out_carry,
  output logic [63:0]          out_sum
);
  import imsq_pkg::*;

  logic        s1_valid, s2_valid, s3_valid;
  logic        en1, en2, en3;
  carry_t      s1_carry, s2_carry, s3_carry;
  logic [63:0] s1_x, s1_mask;
  logic [63:0] s2_elt, s2_low;
  logic [63:0] s3_sum;

  carry_t      c_next;
  logic [63:0] x_next, mask_next;
  logic [3:0]  cz, co;
  logic        eq32, eq16, eq8, eq4, eq2;
  logic [63:0] elt_raw, elt_next, low_next;

  assign en3      = !s3_valid || out_ready;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // Stage 1 tests.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cz[i] = in_value[16*i +: 16] == 16'd0;
      co[i] = in_value[16*i +: 16] == CHUNK_ONES;
    end
    x_next = in_is_64bit ? in_value : {in_value[31:0], in_value[31:0]};
    eq32 = {x_next[31:0], x_next[63:32]} == x_next;
    eq16 = {x_next[15:0], x_next[63:16]} == x_next;
    eq8  = {x_next[7:0],  x_next[63:8]}  == x_next;
    eq4  = {x_next[3:0],  x_next[63:4]}  == x_next;
    eq2  = {x_next[1:0],  x_next[63:2]}  == x_next;
    // The element size halves only while every coarser rotation matched.
    if (!eq32)      mask_next = '1;
    else if (!eq16) mask_next = 64'h0000_0000_FFFF_FFFF;
    else if (!eq8)  mask_next = 64'h0000_0000_0000_FFFF;
    else if (!eq4)  mask_next = 64'h0000_0000_0000_00FF;
    else if (!eq2)  mask_next = 64'h0000_0000_0000_000F;
    else            mask_next = 64'h0000_0000_0000_0003;

    c_next.dest_reg   = in_reg;
    c_next.value      = in_value;
    c_next.is_64bit   = in_is_64bit;
    c_next.chunk_zero = cz;
    c_next.chunk_ones = co;
    c_next.halves_eq  = in_value[31:0] == in_value[63:32];
    c_next.trivial    = (x_next == 64'd0) || (x_next == '1);
    if (in_is_64bit)
      c_next.wide = at_most_one(~cz) || at_most_one(~co);
    else
      c_next.wide = cz[0] || cz[1] || co[0] || co[1];
  end

  // Stage 2: element with its low run moved to the bottom.
  always_comb begin
    elt_raw  = s1_x & s1_mask;
    elt_next = elt_raw[0] ? (~elt_raw & s1_mask) : elt_raw;
    low_next = elt_next & (64'd0 - elt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= in_valid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_carry <= c_next;
      s1_x     <= x_next;
      s1_mask  <= mask_next;
    end
    if (en2) begin
      s2_carry <= s1_carry;
      s2_elt   <= elt_next;
      s2_low   <= low_next;
    end
    if (en3) begin
      s3_carry <= s2_carry;
      s3_sum   <= s2_elt + s2_low;
    end
  end

  assign out_valid = s3_valid;
  assign out_carry = s3_carry;
  assign out_sum   = s3_sum;

endmodule

`default_nettype wire

@@ hdl/imsq_plan.sv @@
// ----------------------------------------------------------------------------
// imsq_plan: instruction run builder
// Finishes the bitmask test and lays out the whole run of one item in a
// register stage of up to four result words.
// ----------------------------------------------------------------------------
`default_nettype none

module imsq_plan (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  imsq_pkg::carry_t       in_carry,
  input  wire logic [63:0]       in_sum,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output imsq_pkg::plan_t        out_plan
);
  import imsq_pkg::*;

  logic   pvalid;
  plan_t  plan;
  plan_t  plan_next;
  logic   en;
  logic   mask_fit, fit;
  logic   use_z, skip, emit;
  logic [2:0] zeros, ones, n, chunks;
  logic [15:0] chunk;
  result_t r;

  assign en       = !pvalid || out_ready;
  assign in_ready = en;

  always_comb begin
    mask_fit = !in_carry.trivial && ((in_sum & (in_sum - 64'd1)) == 64'd0);
    fit      = in_carry.wide || mask_fit;
    zeros    = 3'($countones(in_carry.chunk_zero));
    ones     = 3'($countones(in_carry.chunk_ones & ~in_carry.chunk_zero));
    use_z    = zeros >= ones;
    chunks   = in_carry.halves_eq ? 3'd2 : 3'd4;
    plan_next = '0;
    n = 3'd0;
    r = '0;
    r.dest_reg = in_carry.dest_reg;
    chunk = 16'd0;
    skip = 1'b0;
    emit = 1'b0;
    if (fit) begin
      r.kind    = KIND_MOV;
      r.operand = in_carry.value;
      plan_next.ent[0] = r;
      n = 3'd1;
    end else if (!in_carry.is_64bit) begin
      r.kind    = KIND_MOV;
      r.operand = {48'd0, in_carry.value[15:0]};
      plan_next.ent[0] = r;
      r.kind    = KIND_MOVK;
      r.operand = {48'd0, in_carry.value[31:16]};
      r.shift   = 6'd16;
      plan_next.ent[1] = r;
      n = 3'd2;
    end else begin
      for (int i = 0; i < 4; i++) begin
        chunk = in_carry.value[16*i +: 16];
        skip  = use_z ? in_carry.chunk_zero[i] : in_carry.chunk_ones[i];
        emit  = (3'(i) < chunks) && !skip;
        if (emit) begin
          r.shift = 6'(16 * i);
          if (n != 3'd0) begin
            r.kind    = KIND_MOVK;
            r.operand = {48'd0, chunk};
          end else if (use_z) begin
            r.kind    = KIND_MOVZ;
            r.operand = {48'd0, chunk};
          end else begin
            r.kind    = KIND_MOVN;
            r.operand = {48'd0, ~chunk};
          end
          plan_next.ent[n[1:0]] = r;
          n = n + 3'd1;
        end
      end
      if (in_carry.halves_eq) begin
        r.kind    = KIND_BFM;
        r.operand = 64'd0;
        r.shift   = BFM_SHIFT;
        plan_next.ent[n[1:0]] = r;
        n = n + 3'd1;
      end
    end
    for (int j = 0; j < MAX_RESULTS; j++)
      plan_next.ent[j].last = (n != 3'd0) && (3'(j) == n - 3'd1);
    plan_next.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= 1'b0;
    end else if (en) begin
      // An empty run produces no words at all.
      pvalid <= in_valid && (plan_next.cnt != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) plan <= plan_next;
  end

  assign out_valid = pvalid;
  assign out_plan  = plan;

endmodule

`default_nettype wire

@@ hdl/imsq_emit.sv @@
// ----------------------------------------------------------------------------
// imsq_emit: result serializer
// Holds one planned run and sends its words one per cycle, unless stalled,
// through an output register; the next run is taken as the last word leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module imsq_emit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  imsq_pkg::plan_t        in_plan,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output imsq_pkg::result_t      out_word
);
  import imsq_pkg::*;

  logic    bvalid;
  plan_t   hold;
  logic [1:0] idx;
  logic    ovalid;
  result_t oword;
  logic    load_o, take, done;

  assign load_o   = !ovalid || out_ready;
  assign take     = bvalid && load_o;
  assign done     = take && (idx == 2'(hold.cnt - 3'd1));
  assign in_ready = !bvalid || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid <= 1'b0;
      ovalid <= 1'b0;
      idx    <= 2'd0;
    end else begin
      if (in_ready) bvalid <= in_valid;
      if (load_o)   ovalid <= bvalid;
      if (done)      idx <= 2'd0;
      else if (take) idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) hold <= in_plan;
    if (take) oword <= hold.ent[idx];
  end

  assign out_valid = ovalid;
  assign out_word  = oword;

endmodule

`default_nettype wire

@@ hdl/immediate_materialization_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// immediate_materialization_sequencer_top: AArch64 immediate load sequencer
// Turns a register, a 64-bit immediate and an operand size into the run
// of move instructions that loads the immediate.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready/s_tdata/s_tuser, one immediate
//   per word, with the operand size flag on s_tuser.
//   Each input word yields a run of one to four result words on
//   m_tvalid/m_tready/m_tdata/m_tuser, with the instruction kind on m_tuser
//   and m_tlast set on the final word of a run.
//   From input acceptance to the first result word an item passes
//   three classification stages, the run builder, the run buffer and the
//   output register. Result words leave at one per cycle while m_tready is
//   high, on the single result channel. A new input word is accepted every
//   cycle while the pipeline has room.
//   Reset (rst, synchronous) empties every stage; no word is in flight.
//   When the receiver holds m_tready low the output word stays put, the
//   stages fill up behind it and s_tready drops once all are occupied.
//   Nothing is dropped or repeated across a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module immediate_materialization_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [4:0] target_register, [68:5] value, [71:69] zero
  input  wire logic [71:0] s_tdata,
  // [0] is_64bit
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [4:0] dest_reg, [68:5] operand, [74:69] shift, [79:75] zero
  output logic [79:0]      m_tdata,
  // [2:0] kind
  output logic [2:0]       m_tuser,
  output logic             m_tlast
);
  import imsq_pkg::*;

  logic        cls_valid, cls_ready;
  carry_t      cls_carry;
  logic [63:0] cls_sum;
  logic        plan_valid, plan_ready;
  plan_t       plan;
  result_t     word;

  imsq_classify u_classify (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_reg      (s_tdata[4:0]),
    .in_value    (s_tdata[68:5]),
    .in_is_64bit (s_tuser),
    .out_valid   (cls_valid),
    .out_ready   (cls_ready),
    .out_carry   (cls_carry),
    .out_sum     (cls_sum)
  );

  imsq_plan u_plan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cls_valid),
    .in_ready  (cls_ready),
    .in_carry  (cls_carry),
    .in_sum    (cls_sum),
    .out_valid (plan_valid),
    .out_ready (plan_ready),
    .out_plan  (plan)
  );

  imsq_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (plan_valid),
    .in_ready  (plan_ready),
    .in_plan   (plan),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (word)
  );

  assign m_tdata = {5'b00000, word.shift, word.operand, word.dest_reg};
  assign m_tuser = word.kind;
  assign m_tlast = word.last;

endmodule

`default_nettype wire

@@ hdl/imsq_checker.sv @@
// ----------------------------------------------------------------------------
// imsq_checker: port-level checks of the immediate sequencer
// Watches the result channel for stall behavior and well-formed words.
// ----------------------------------------------------------------------------
`default_nettype none

module imsq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [79:0] m_tdata,
  input wire logic [2:0]  m_tuser,
  input wire logic        m_tlast
);
  import imsq_pkg::*;

  // A stalled result word must not change.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
      $stable(m_tlast))
    else $error("result word changed during stall");

  // Reset leaves no result word pending.
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result word valid after reset");

  // A bitfield copy always closes its run with a zero operand.
  a_bfm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_BFM) |->
      m_tlast && (m_tdata[68:5] == 64'd0) && (m_tdata[74:69] == BFM_SHIFT))
    else $error("malformed bitfield copy word");

  // Chunk moves carry a 16-bit operand and a known kind.
  a_chunk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_MOV) |->
      (m_tdata[68:21] == 48'd0) && (m_tuser <= KIND_BFM) &&
      (m_tdata[79:75] == 5'd0))
    else $error("malformed chunk move word");

endmodule

bind immediate_materialization_sequencer_top imsq_checker u_imsq_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/tb_immediate_materialization_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// tb_immediate_materialization_sequencer_top: self-checking bench
// Sends immediates with their operand size and checks every emitted word
// against a typed-in word or a behavioral model of the move sequencing. A
// directed table of edge cases runs first, then randomly shaped values. The
// sender pauses in bursts and the receiver stalls on a changing pattern.
// ----------------------------------------------------------------------------
module tb_immediate_materialization_sequencer_top;
  timeunit 1ns;
  timeprecision 1ps;

  import imsq_pkg::*;

  localparam int RANDOM_ITEMS = 196;
  localparam int DRAIN_CYCLES = 24;

  typedef struct packed {
    logic [4:0]  rg;
    logic [63:0] value;
    logic        wide64;
    logic        typed;    // expected word typed in below, single whole move
    kind_t       kind;
    logic [63:0] operand;
  } row_t;

  localparam int NUM_ROWS = 24;
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{5'd0,  64'h0000_0000_0000_0000, 1'b1, 1'b1, KIND_MOV, 64'h0000_0000_0000_0000},
    '{5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, KIND_MOV, 64'hFFFF_FFFF_FFFF_FFFF},
    '{5'd5,  64'h0000_0000_0000_1234, 1'b1, 1'b1, KIND_MOV, 64'h0000_0000_0000_1234},
    '{5'd7,  64'h1234_0000_0000_0000, 1'b1, 1'b1, KIND_MOV, 64'h1234_0000_0000_0000},
    '{5'd9,  64'h0000_ABCD_0000_0000, 1'b1, 1'b1, KIND_MOV, 64'h0000_ABCD_0000_0000},
    '{5'd10, 64'hFFFF_FFFF_FFFF_EDCB, 1'b1, 1'b1, KIND_MOV, 64'hFFFF_FFFF_FFFF_EDCB},
    '{5'd11, 64'h5555_5555_5555_5555, 1'b1, 1'b1, KIND_MOV, 64'h5555_5555_5555_5555},
    '{5'd12, 64'h00FF_00FF_00FF_00FF, 1'b1, 1'b1, KIND_MOV, 64'h00FF_00FF_00FF_00FF},
    '{5'd13, 64'h8000_0000_0000_0001, 1'b1, 1'b1, KIND_MOV, 64'h8000_0000_0000_0001},
    '{5'd14, 64'hDEAD_BEEF_1234_5678, 1'b0, 1'b0, KIND_MOV, 64'h0},
    '{5'd15, 64'hABCD_EF01_0000_1234, 1'b0, 1'b1, KIND_MOV, 64'hABCD_EF01_0000_1234},
    '{5'd16, 64'h1111_2222_FFFF_1234, 1'b0, 1'b1, KIND_MOV, 64'h1111_2222_FFFF_1234},
    '{5'd17, 64'hFFFF_0000_0F0F_0F0F, 1'b0, 1'b1, KIND_MOV, 64'hFFFF_0000_0F0F_0F0F},
    '{5'd18, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1, KIND_MOV, 64'hFFFF_FFFF_0000_0000},
    '{5'd19, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b1, KIND_MOV, 64'hFFFF_FFFF_FFFF_FFFF},
    '{5'd20, 64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd21, 64'hFFFF_FFFF_1234_5678, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd22, 64'h1234_0000_5678_0000, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd23, 64'h1234_5678_1234_5678, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd24, 64'h0000_1234_0000_1234, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd25, 64'hFFFF_1234_FFFF_1234, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd26, 64'h0000_FFFF_1234_5678, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd27, 64'h1234_FFFF_FFFF_5678, 1'b1, 1'b0, KIND_MOV, 64'h0},
    '{5'd31, 64'h0000_0000_8001_7FFE, 1'b0, 1'b0, KIND_MOV, 64'h0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  result_t pending_insns [$];
  int      bad_words = 0;
  int      burst_left = 3;
  int      ready_mode = 0;
  int      ready_phase = 0;
  result_t seen_word, want_word;

  immediate_materialization_sequencer_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit fits_move_wide(input logic [63:0] v, input logic w);
    if (w) begin
      if ((v & 64'hFFFF_0000_0000_0000) == v || (v & 64'h0000_FFFF_0000_0000) == v)
        return 1'b1;
    end else begin
      v = {32'd0, v[31:0]};
    end
    return (v & 64'hFFFF_0000) == v || (v & 64'h0000_FFFF) == v;
  endfunction

  // Architectural bitmask immediate: a rotated run of ones, replicated over
  // an element of 2 to 64 bits. 32-bit values are tested doubled.
  function automatic bit is_logical_imm(input logic [63:0] v, input logic w);
    logic [63:0] x, rot, m, elt, t;
    int e, h;
    x = w ? v : {v[31:0], v[31:0]};
    if (x == '0 || &x)
      return 1'b0;
    e = 64;
    while (e > 2) begin
      h = e / 2;
      rot = (x >> h) | (x << (64 - h));
      if (rot != x)
        break;
      e = h;
    end
    m = (e == 64) ? '1 : ((64'd1 << e) - 64'd1);
    elt = x & m;
    if (elt[0])
      elt = ~elt & m;
    t = elt + (elt & (~elt + 64'd1));
    return (t & (t - 64'd1)) == '0;
  endfunction

  // Queues the instruction run that loads v into register rg.
  function automatic void expand_immediate(input logic [4:0] rg, input logic [63:0] v,
                                           input logic w);
    result_t     run [4];
    int          n, zeros, ones, nchunks;
    bit          use_z, started, halves_eq;
    logic [15:0] c;
    if (fits_move_wide(v, w) || fits_move_wide(~v, w) || is_logical_imm(v, w)) begin
      pending_insns.push_back(result_t'{KIND_MOV, rg, v, 6'd0, 1'b1});
      return;
    end
    if (!w) begin
      pending_insns.push_back(result_t'{KIND_MOV, rg, {48'd0, v[15:0]}, 6'd0, 1'b0});
      pending_insns.push_back(result_t'{KIND_MOVK, rg, {48'd0, v[31:16]}, 6'd16, 1'b1});
      return;
    end
    n = 0;
    zeros = 0;
    ones = 0;
    started = 1'b0;
    for (int i = 0; i < 4; i++) begin
      c = v[16*i +: 16];
      if (c == 16'd0)
        zeros++;
      else if (c == CHUNK_ONES)
        ones++;
    end
    use_z = zeros >= ones;
    halves_eq = v[31:0] == v[63:32];
    nchunks = halves_eq ? 2 : 4;
    for (int i = 0; i < nchunks; i++) begin
      c = v[16*i +: 16];
      if (use_z ? (c == 16'd0) : (c == CHUNK_ONES))
        continue;
      if (started)
        run[n] = result_t'{KIND_MOVK, rg, {48'd0, c}, 6'(16 * i), 1'b0};
      else if (use_z)
        run[n] = result_t'{KIND_MOVZ, rg, {48'd0, c}, 6'(16 * i), 1'b0};
      else
        run[n] = result_t'{KIND_MOVN, rg, {48'd0, ~c}, 6'(16 * i), 1'b0};
      started = 1'b1;
      n++;
    end
    if (halves_eq) begin
      run[n] = result_t'{KIND_BFM, rg, 64'd0, BFM_SHIFT, 1'b0};
      n++;
    end
    if (n > 0)
      run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++)
      pending_insns.push_back(run[i]);
  endfunction

  function automatic logic [15:0] pick_chunk();
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return CHUNK_ONES;
      default: return 16'($urandom);
    endcase
  endfunction

  // Shapes random values so that every sequencing path is reached often.
  task automatic pick_random(output logic [63:0] v, output logic w);
    int e, len, rot;
    logic [63:0] m, elt;
    w = 1'b1;
    case ($urandom_range(0, 9))
      0: begin
        v = {$urandom, $urandom};
        w = 1'($urandom);
      end
      1, 2, 3: v = {pick_chunk(), pick_chunk(), pick_chunk(), pick_chunk()};
      4: begin
        v[31:0] = {pick_chunk(), pick_chunk()};
        v[63:32] = v[31:0];
      end
      5: begin
        e = 2 << $urandom_range(0, 5);
        len = $urandom_range(1, e - 1);
        rot = $urandom_range(0, e - 1);
        m = (e == 64) ? '1 : ((64'd1 << e) - 64'd1);
        elt = (64'd1 << len) - 64'd1;
        elt = ((elt >> rot) | (elt << (e - rot))) & m;
        v = '0;
        for (int i = 0; i < 64; i += e)
          v |= elt << i;
        w = (e < 64) ? 1'($urandom) : 1'b1;
      end
      6: begin
        v = {48'd0, 16'($urandom)} << (16 * $urandom_range(0, 3));
        if ($urandom_range(0, 1))
          v = ~v;
        w = 1'($urandom);
      end
      7, 8: begin
        v = {$urandom, $urandom};
        w = 1'b0;
      end
      default: begin
        v = {$urandom, pick_chunk(), pick_chunk()};
        w = 1'b0;
      end
    endcase
  endtask

  // Called at a falling edge; leaves the bus idle for a while between bursts.
  task automatic pace_sender();
    logic [95:0] noise;
    if (burst_left == 0) begin
      noise = {$urandom, $urandom, $urandom};
      s_tvalid <= 1'b0;
      s_tdata <= noise[71:0];
      s_tuser <= noise[72];
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  task automatic send_word(input logic [4:0] rg, input logic [63:0] v, input logic w,
                           input logic typed, input kind_t k, input logic [63:0] op);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, v, rg};
    s_tuser <= w;
    do
      @(posedge clk);
    while (s_tready !== 1'b1);
    if (typed)
      pending_insns.push_back(result_t'{k, rg, op, 6'd0, 1'b1});
    else
      expand_immediate(rg, v, w);
    @(negedge clk);
  endtask

  // Receiver stalls: always ready, coin flip, one cycle in four, or rare drops.
  always @(negedge clk) begin
    if (ready_phase % 64 == 0)
      ready_mode <= $urandom_range(0, 3);
    ready_phase <= ready_phase + 1;
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= 1'($urandom);
      2: m_tready <= (ready_phase % 4 == 3);
      default: m_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      seen_word = result_t'{kind_t'(m_tuser), m_tdata[4:0], m_tdata[68:5],
                            m_tdata[74:69], m_tlast};
      if (pending_insns.size() == 0) begin
        bad_words++;
        $display("%0t: unexpected word kind=%0d reg=%0d operand=%h shift=%0d last=%0b",
                 $time, seen_word.kind, seen_word.dest_reg, seen_word.operand,
                 seen_word.shift, seen_word.last);
      end else begin
        want_word = pending_insns.pop_front();
        if (seen_word.kind !== want_word.kind || seen_word.dest_reg !== want_word.dest_reg ||
            seen_word.operand !== want_word.operand || seen_word.shift !== want_word.shift ||
            seen_word.last !== want_word.last) begin
          bad_words++;
          $display("%0t: expected kind=%0d reg=%0d operand=%h shift=%0d last=%0b", $time,
                   want_word.kind, want_word.dest_reg, want_word.operand,
                   want_word.shift, want_word.last);
          $display("%0t: actual   kind=%0d reg=%0d operand=%h shift=%0d last=%0b", $time,
                   seen_word.kind, seen_word.dest_reg, seen_word.operand,
                   seen_word.shift, seen_word.last);
        end
      end
    end
  end

  initial begin
    logic [63:0] v;
    logic        w;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (DIRECTED[i]) begin
      pace_sender();
      send_word(DIRECTED[i].rg, DIRECTED[i].value, DIRECTED[i].wide64,
                DIRECTED[i].typed, DIRECTED[i].kind, DIRECTED[i].operand);
    end
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick_random(v, w);
      pace_sender();
      send_word(5'($urandom_range(0, 31)), v, w, 1'b0, KIND_MOV, 64'd0);
    end
    s_tvalid <= 1'b0;
    while (pending_insns.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_words == 0 && pending_insns.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
